// ===== sv/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg - shared types and constants of the json string unescaper
// Channel payloads, the front-to-back job record, parser phases and
// character codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } jsu_req_type;

   // result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last_of_run;
   } jsu_rsp_type;

   // result kinds
   localparam logic [1:0] KIND_TEXT = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // parser phases
   typedef enum logic [3:0] {
      PH_IDLE        = 4'd0,
      PH_STR         = 4'd1,
      PH_ESC         = 4'd2,
      PH_HEX0        = 4'd3,
      PH_HEX1        = 4'd4,
      PH_HEX2        = 4'd5,
      PH_HEX3        = 4'd6,
      PH_AFTER_HI    = 4'd7,
      PH_AFTER_HI_BS = 4'd8,
      PH_LOW0        = 4'd9,
      PH_LOW1        = 4'd10,
      PH_LOW2        = 4'd11,
      PH_LOW3        = 4'd12,
      PH_DRAIN       = 4'd13
   } jsu_phase_type;

   // main part of a job
   typedef enum logic [2:0] {
      MAIN_NONE = 3'd0,
      MAIN_BYTE = 3'd1,
      MAIN_CP   = 3'd2,
      MAIN_DONE = 3'd3,
      MAIN_ERR  = 3'd4
   } jsu_main_type;

   localparam int CP_W = 21;

   // work for the back end caused by one input byte
   typedef struct packed {
      logic              flush_en;
      logic [15:0]       flush_cp;
      jsu_main_type      main_sel;
      logic [CP_W-1:0]   main_cp;
   } jsu_job_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int MAX_RUN = 6;
   localparam int RUN_CW  = 3;

   // character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_TAB    = 8'h09;

   // surrogate ranges
   localparam logic [15:0] HI_MIN = 16'hd800;
   localparam logic [15:0] HI_MAX = 16'hdbff;
   localparam logic [15:0] LO_MIN = 16'hdc00;
   localparam logic [15:0] LO_MAX = 16'hdfff;

endpackage

// ===== sv/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue - job queue between front and back end
// Small flop-based fifo of job records.
// ----------------------------------------------------------------------------
module jsu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsu_pkg::jsu_job_type push_job,
   output logic                full,
   input  logic                pop,
   output jsu_pkg::jsu_job_type pop_job,
   output logic                empty
);

   jsu_pkg::jsu_job_type                   entry_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QUEUE_AW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::QUEUE_AW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::QUEUE_CW-1:0]           count_ff, count_in;

   assign full    = (count_ff == jsu_pkg::QUEUE_CW'(jsu_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front - byte parser
// Tracks the string phase, collects hex digits and held high surrogates,
// and turns each accepted byte into at most one job record.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  jsu_pkg::jsu_req_type req,
   output logic                 job_valid,
   output jsu_pkg::jsu_job_type job
);

   jsu_pkg::jsu_phase_type phase_ff, phase_in, phase_proc;
   logic [15:0]            acc_ff, acc_in;
   logic [15:0]            hi_ff, hi_in;

   logic [7:0]             b;
   logic                   is_quote, is_bslash, is_u;
   logic                   hex_ok;
   logic [3:0]             hex_val;
   logic [15:0]            acc_next;
   logic                   acc_is_hi, acc_is_lo;
   logic [10:0]            pair_top;
   logic [7:0]             esc_byte;
   jsu_pkg::jsu_main_type  esc_sel, body_sel, proc_sel;
   logic                   proc_flush, end_hit;
   logic                   in_hex, in_low;

   assign b         = req.data_byte;
   assign is_quote  = (b == jsu_pkg::CH_QUOTE);
   assign is_bslash = (b == jsu_pkg::CH_BSLASH);
   assign is_u      = (b == jsu_pkg::CH_U);

   // hex digit
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         hex_val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         hex_val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         hex_val = 4'(b - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc_next  = {acc_ff[11:0], hex_val};
   assign acc_is_hi = (acc_next >= jsu_pkg::HI_MIN) && (acc_next <= jsu_pkg::HI_MAX);
   assign acc_is_lo = (acc_next >= jsu_pkg::LO_MIN) && (acc_next <= jsu_pkg::LO_MAX);
   // supplementary plane: 0x10000 + (hi - 0xd800) * 1024 + (lo - 0xdc00)
   assign pair_top  = {1'b0, hi_ff[9:0]} + 11'h040;

   // escape letter
   always_comb begin
      esc_byte = b;
      esc_sel  = jsu_pkg::MAIN_BYTE;
      case (b) inside
         jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: esc_byte = b;
         jsu_pkg::CH_B, jsu_pkg::CH_F:                             esc_byte = jsu_pkg::CH_SPACE;
         jsu_pkg::CH_N: esc_byte = jsu_pkg::CH_LF;
         jsu_pkg::CH_R: esc_byte = jsu_pkg::CH_CR;
         jsu_pkg::CH_T: esc_byte = jsu_pkg::CH_TAB;
         jsu_pkg::CH_U: esc_sel  = jsu_pkg::MAIN_NONE;
         default:       esc_sel  = jsu_pkg::MAIN_ERR;
      endcase
   end

   // string body byte
   always_comb begin
      if (is_quote) begin
         body_sel = jsu_pkg::MAIN_DONE;
      end else if (is_bslash || b == jsu_pkg::CH_NUL) begin
         body_sel = jsu_pkg::MAIN_NONE;
      end else begin
         body_sel = jsu_pkg::MAIN_BYTE;
      end
   end

   assign in_hex = (phase_ff == jsu_pkg::PH_HEX0) || (phase_ff == jsu_pkg::PH_HEX1) ||
                   (phase_ff == jsu_pkg::PH_HEX2) || (phase_ff == jsu_pkg::PH_HEX3);
   assign in_low = (phase_ff == jsu_pkg::PH_LOW0) || (phase_ff == jsu_pkg::PH_LOW1) ||
                   (phase_ff == jsu_pkg::PH_LOW2) || (phase_ff == jsu_pkg::PH_LOW3);

   // outputs: job record
   always_comb begin
      proc_flush  = 1'b0;
      proc_sel    = jsu_pkg::MAIN_NONE;
      job.main_cp = {13'd0, b};
      unique case (phase_ff)
         jsu_pkg::PH_IDLE: begin
            if (!is_quote) proc_sel = jsu_pkg::MAIN_ERR;
         end
         jsu_pkg::PH_STR: begin
            proc_sel = body_sel;
         end
         jsu_pkg::PH_ESC: begin
            proc_sel    = esc_sel;
            job.main_cp = {13'd0, esc_byte};
         end
         jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2,
         jsu_pkg::PH_LOW0, jsu_pkg::PH_LOW1, jsu_pkg::PH_LOW2: begin
            if (!hex_ok) proc_sel = jsu_pkg::MAIN_ERR;
         end
         jsu_pkg::PH_HEX3: begin
            if (!hex_ok) begin
               proc_sel = jsu_pkg::MAIN_ERR;
            end else if (!acc_is_hi) begin
               proc_sel    = jsu_pkg::MAIN_CP;
               job.main_cp = {5'd0, acc_next};
            end
         end
         jsu_pkg::PH_AFTER_HI: begin
            if (!is_bslash) begin
               proc_flush = 1'b1;
               proc_sel   = body_sel;
            end
         end
         jsu_pkg::PH_AFTER_HI_BS: begin
            if (!is_u) begin
               proc_flush  = 1'b1;
               proc_sel    = esc_sel;
               job.main_cp = {13'd0, esc_byte};
            end
         end
         jsu_pkg::PH_LOW3: begin
            if (!hex_ok) begin
               proc_sel = jsu_pkg::MAIN_ERR;
            end else if (acc_is_lo) begin
               proc_sel    = jsu_pkg::MAIN_CP;
               job.main_cp = {pair_top, acc_next[9:0]};
            end else begin
               proc_flush = 1'b1;
               if (!acc_is_hi) begin
                  proc_sel    = jsu_pkg::MAIN_CP;
                  job.main_cp = {5'd0, acc_next};
               end
            end
         end
         jsu_pkg::PH_DRAIN: begin
         end
         default: begin
         end
      endcase

      end_hit = (proc_sel == jsu_pkg::MAIN_DONE) || (proc_sel == jsu_pkg::MAIN_ERR);

      // buffer ends inside the string: a lone error replaces everything
      if (req.final_byte && !end_hit && phase_ff != jsu_pkg::PH_DRAIN) begin
         job.flush_en = 1'b0;
         job.main_sel = jsu_pkg::MAIN_ERR;
      end else begin
         job.flush_en = proc_flush;
         job.main_sel = proc_sel;
      end
      job.flush_cp = hi_ff;
      job_valid    = accept && (job.flush_en || job.main_sel != jsu_pkg::MAIN_NONE);
   end

   // next state
   always_comb begin
      unique case (phase_ff)
         jsu_pkg::PH_IDLE: phase_proc = jsu_pkg::PH_STR;
         jsu_pkg::PH_STR:  phase_proc = is_bslash ? jsu_pkg::PH_ESC : jsu_pkg::PH_STR;
         jsu_pkg::PH_ESC:  phase_proc = is_u ? jsu_pkg::PH_HEX0 : jsu_pkg::PH_STR;
         jsu_pkg::PH_HEX0: phase_proc = jsu_pkg::PH_HEX1;
         jsu_pkg::PH_HEX1: phase_proc = jsu_pkg::PH_HEX2;
         jsu_pkg::PH_HEX2: phase_proc = jsu_pkg::PH_HEX3;
         jsu_pkg::PH_HEX3: phase_proc = acc_is_hi ? jsu_pkg::PH_AFTER_HI : jsu_pkg::PH_STR;
         jsu_pkg::PH_AFTER_HI: begin
            phase_proc = is_bslash ? jsu_pkg::PH_AFTER_HI_BS : jsu_pkg::PH_STR;
         end
         jsu_pkg::PH_AFTER_HI_BS: begin
            if (is_u) begin
               phase_proc = jsu_pkg::PH_LOW0;
            end else begin
               phase_proc = jsu_pkg::PH_STR;
            end
         end
         jsu_pkg::PH_LOW0: phase_proc = jsu_pkg::PH_LOW1;
         jsu_pkg::PH_LOW1: phase_proc = jsu_pkg::PH_LOW2;
         jsu_pkg::PH_LOW2: phase_proc = jsu_pkg::PH_LOW3;
         jsu_pkg::PH_LOW3: begin
            if (!acc_is_lo && acc_is_hi) begin
               phase_proc = jsu_pkg::PH_AFTER_HI;
            end else begin
               phase_proc = jsu_pkg::PH_STR;
            end
         end
         jsu_pkg::PH_DRAIN: phase_proc = jsu_pkg::PH_DRAIN;
         default:           phase_proc = jsu_pkg::PH_DRAIN;
      endcase

      if (!accept) begin
         phase_in = phase_ff;
      end else if (end_hit) begin
         phase_in = req.final_byte ? jsu_pkg::PH_IDLE : jsu_pkg::PH_DRAIN;
      end else if (req.final_byte) begin
         phase_in = jsu_pkg::PH_IDLE;
      end else begin
         phase_in = phase_proc;
      end
   end

   // hex digits and held high surrogate
   always_comb begin
      acc_in = acc_ff;
      hi_in  = hi_ff;
      if (accept && (in_hex || in_low)) begin
         acc_in = acc_next;
      end
      if (accept && hex_ok && acc_is_hi &&
          (phase_ff == jsu_pkg::PH_HEX3 ||
           (phase_ff == jsu_pkg::PH_LOW3 && !acc_is_lo))) begin
         hi_in = acc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsu_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      hi_ff  <= hi_in;
   end

endmodule

// ===== sv/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back - result emitter
// Expands one job into its run of results (utf-8 bytes, then done or
// error) and shifts them out one per transfer.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_empty,
   input  jsu_pkg::jsu_job_type  job,
   output logic                  job_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jsu_pkg::jsu_rsp_type  rsp_data
);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
   } jsu_slot_type;

   jsu_slot_type                 slot_ff [jsu_pkg::MAX_RUN];
   jsu_slot_type                 slot_in [jsu_pkg::MAX_RUN];
   jsu_slot_type                 load    [jsu_pkg::MAX_RUN];
   jsu_slot_type                 main_s  [4];
   jsu_slot_type                 flush_s [3];
   logic [jsu_pkg::RUN_CW-1:0]   count_ff, count_in, load_count, main_n;
   logic [jsu_pkg::CP_W-1:0]     cp;
   logic                         take, refill;

   assign cp = job.main_cp;

   // main part as utf-8 or a closing result
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         main_s[k] = '{kind: jsu_pkg::KIND_TEXT, value: 8'h00};
      end
      main_n = '0;
      case (job.main_sel)
         jsu_pkg::MAIN_BYTE: begin
            main_s[0].value = cp[7:0];
            main_n          = 3'd1;
         end
         jsu_pkg::MAIN_CP: begin
            if (cp <= 21'h00007f) begin
               main_s[0].value = cp[7:0];
               main_n          = 3'd1;
            end else if (cp <= 21'h0007ff) begin
               main_s[0].value = 8'hc0 | {3'd0, cp[10:6]};
               main_s[1].value = 8'h80 | {2'd0, cp[5:0]};
               main_n          = 3'd2;
            end else if (cp <= 21'h00ffff) begin
               main_s[0].value = 8'he0 | {4'd0, cp[15:12]};
               main_s[1].value = 8'h80 | {2'd0, cp[11:6]};
               main_s[2].value = 8'h80 | {2'd0, cp[5:0]};
               main_n          = 3'd3;
            end else begin
               main_s[0].value = 8'hf0 | {5'd0, cp[20:18]};
               main_s[1].value = 8'h80 | {2'd0, cp[17:12]};
               main_s[2].value = 8'h80 | {2'd0, cp[11:6]};
               main_s[3].value = 8'h80 | {2'd0, cp[5:0]};
               main_n          = 3'd4;
            end
         end
         jsu_pkg::MAIN_DONE: begin
            main_s[0].kind = jsu_pkg::KIND_DONE;
            main_n         = 3'd1;
         end
         jsu_pkg::MAIN_ERR: begin
            main_s[0].kind = jsu_pkg::KIND_ERR;
            main_n         = 3'd1;
         end
         default: main_n = '0;
      endcase
   end

   // a held high surrogate always takes three bytes
   always_comb begin
      flush_s[0] = '{kind: jsu_pkg::KIND_TEXT, value: 8'he0 | {4'd0, job.flush_cp[15:12]}};
      flush_s[1] = '{kind: jsu_pkg::KIND_TEXT, value: 8'h80 | {2'd0, job.flush_cp[11:6]}};
      flush_s[2] = '{kind: jsu_pkg::KIND_TEXT, value: 8'h80 | {2'd0, job.flush_cp[5:0]}};
   end

   always_comb begin
      if (job.flush_en) begin
         load[0]    = flush_s[0];
         load[1]    = flush_s[1];
         load[2]    = flush_s[2];
         load[3]    = main_s[0];
         load[4]    = main_s[1];
         load[5]    = main_s[2];
         load_count = main_n + 3'd3;
      end else begin
         load[0]    = main_s[0];
         load[1]    = main_s[1];
         load[2]    = main_s[2];
         load[3]    = main_s[3];
         load[4]    = main_s[3];
         load[5]    = main_s[3];
         load_count = main_n;
      end
   end

   assign rsp_valid            = (count_ff != '0);
   assign take                 = rsp_valid && rsp_ready;
   assign refill               = (count_ff == '0) || (count_ff == 3'd1 && rsp_ready);
   assign job_pop              = refill && !job_empty;
   assign rsp_data.out_byte    = slot_ff[0].value;
   assign rsp_data.kind        = slot_ff[0].kind;
   assign rsp_data.last_of_run = (count_ff == 3'd1);

   always_comb begin
      for (int k = 0; k < jsu_pkg::MAX_RUN; k++) begin
         slot_in[k] = slot_ff[k];
      end
      count_in = count_ff;
      if (job_pop) begin
         for (int k = 0; k < jsu_pkg::MAX_RUN; k++) begin
            slot_in[k] = load[k];
         end
         count_in = load_count;
      end else if (take) begin
         for (int k = 0; k < jsu_pkg::MAX_RUN - 1; k++) begin
            slot_in[k] = slot_ff[k + 1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < jsu_pkg::MAX_RUN; k++) begin
         slot_ff[k] <= slot_in[k];
      end
   end

endmodule

// ===== sv/json_string_unescape_utf8_unit.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit - json string body to utf-8 decoder
// Parses a quoted json string one byte per transfer and emits the decoded
// utf-8 bytes, then a done or error result.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  jsu_req_type {data_byte, final_byte}
//  rsp      out  rsp_valid/rsp_ready  jsu_rsp_type {out_byte, kind, last_of_run}
//
//  one input byte per cycle while the job queue has room; its results
//  leave one per cycle while rsp_ready is high, 0 to 6 of them; the job
//  of a byte is written into the queue, then loaded into the output run.
//  reset is synchronous; it empties the queue and the output run and
//  returns the parser to waiting for an opening quote.
//  a stalled rsp side fills the 4-entry queue, after which req_ready drops.
//
module json_string_unescape_utf8_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  jsu_pkg::jsu_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output jsu_pkg::jsu_rsp_type rsp_data
);

   logic                 req_take;
   logic                 job_push, job_pop;
   logic                 queue_full, queue_empty;
   jsu_pkg::jsu_job_type front_job, back_job;

   // the front only stalls on a full queue, never on the output side
   assign req_ready = !queue_full;
   assign req_take  = req_valid && req_ready;

   // parser: phase, hex digits, held surrogate
   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_take),
      .req       (req_data),
      .job_valid (job_push),
      .job       (front_job)
   );

   // decouples parsing from the multi-byte output runs
   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (queue_full),
      .pop      (job_pop),
      .pop_job  (back_job),
      .empty    (queue_empty)
   );

   // utf-8 encoding and output register
   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (queue_empty),
      .job       (back_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // no job is written into a full queue
   assert property (@(posedge clock) disable iff (reset) job_push |-> !queue_full)
      else $error("job pushed into full queue");

   // done and error always close a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != jsu_pkg::KIND_TEXT |-> rsp_data.last_of_run)
      else $error("closing result not last of run");

   // the result kind is always one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.kind == jsu_pkg::KIND_TEXT ||
                     rsp_data.kind == jsu_pkg::KIND_DONE ||
                     rsp_data.kind == jsu_pkg::KIND_ERR))
      else $error("unused result kind");

   // last transfer of a run with nothing queued leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_of_run && queue_empty |=> !rsp_valid)
      else $error("result appeared without a job");

endmodule
